// ===== rtl/core/mouse_key_accelerator_core_assert.svh =====
// Assertion macros for the mouse key accelerator core.
`ifndef MOUSE_KEY_ACCELERATOR_CORE_ASSERT_SVH
`define MOUSE_KEY_ACCELERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MKA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("mka: invariant violated");
`define MKA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("mka: sequence violated");
`else
`define MKA_ASSERT_ALWAYS(label, cond)
`define MKA_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== rtl/core/mka_pkg.sv =====
`timescale 1ns / 1ps

package mka_pkg;

    localparam int SPEED_WIDTH = 8;
    localparam int SCALE_WIDTH = 11;
    localparam int DELTA_WIDTH = 24;
    localparam int CFG_DATA_WIDTH = 11;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int KMCAND_WIDTH = SCALE_WIDTH + 1;
    localparam int K_WIDTH = KMCAND_WIDTH + SPEED_WIDTH;
    localparam int DELTA_MAX = 8388607;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPEED_MAX = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WHEEL_SCALE = 1'b1;

    localparam logic [SPEED_WIDTH-1:0] SPEED_MAX_RESET = 8'd20;
    localparam logic [SCALE_WIDTH-1:0] WHEEL_SCALE_RESET = 11'd1;
    localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 8'd1;

    localparam logic CMD_KEY = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [2:0] direction;
        logic       pressed;
        logic       auto_repeat;
    } in_word_t;

    typedef struct packed {
        logic                          is_scroll;
        logic signed [DELTA_WIDTH-1:0] first_delta;
        logic signed [DELTA_WIDTH-1:0] second_delta;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic step;
    } mul_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_K,
        ST_LOAD_C,
        ST_MUL_C,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/mouse_key_accelerator_core.sv =====
// Key events produce no word. An armed tick is worked out by the bit-serial multipliers,
// first over the speed and then over the count bits, and its word is registered on leaving
// ST_DONE, which waits while an earlier word is still unaccepted; no new item is taken
// until the sequencer is back in ST_IDLE.
// Reset (aresetn low, synchronous) clears the counts, mode and arming, sets speed to 1,
// and restores speed_max to 20 and wheel_scale to 1.
`timescale 1ns / 1ps
`include "mouse_key_accelerator_core_assert.svh"

module mouse_key_accelerator_core #(
    parameter int COUNT_WIDTH = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  mka_pkg::in_word_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output mka_pkg::out_word_t                    m_data,
    input  logic                                  cfg_wr_en,
    input  logic [mka_pkg::CFG_INDEX_WIDTH-1:0]   cfg_addr,
    input  logic [mka_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    localparam int PW = mka_pkg::K_WIDTH + COUNT_WIDTH;
    localparam int SAT_W = (PW > mka_pkg::DELTA_WIDTH) ? PW : mka_pkg::DELTA_WIDTH + 1;
    localparam int CNT_W = $clog2(mka_pkg::SPEED_WIDTH);
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    mka_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [COUNT_WIDTH-1:0]       x_count_reg, x_count_next;
    logic signed [COUNT_WIDTH-1:0]       y_count_reg, y_count_next;
    logic [mka_pkg::SPEED_WIDTH-1:0]     speed_reg, speed_next;
    logic                                scroll_mode_reg, scroll_mode_next;
    logic                                armed_reg, armed_next;
    logic [mka_pkg::SPEED_WIDTH-1:0]     speed_max_reg;
    logic [mka_pkg::SCALE_WIDTH-1:0]     wheel_scale_reg;

    logic                                m_valid_reg, m_valid_next;
    mka_pkg::out_word_t                  m_data_reg, m_data_next;

    logic                                s_accept;
    logic                                tick_go;
    logic                                out_load;
    mka_pkg::mul_ctl_t                   k_ctl;
    mka_pkg::mul_ctl_t                   lane_ctl;

    logic [mka_pkg::KMCAND_WIDTH-1:0]    k_mcand;
    logic [mka_pkg::K_WIDTH-1:0]         k_product;
    logic signed [COUNT_WIDTH-1:0]       a_src, b_src;
    logic [COUNT_WIDTH-1:0]              a_mag, b_mag;
    logic [PW-1:0]                       a_product, b_product;
    logic                                a_neg, b_neg;

    logic                                step_up;
    logic signed [COUNT_WIDTH-1:0]       x_key, y_key;

    function automatic logic signed [COUNT_WIDTH-1:0] count_step(
        input logic signed [COUNT_WIDTH-1:0] c,
        input logic                          up
    );
        logic signed [COUNT_WIDTH-1:0] r;
        r = c;
        if (up) begin
            if (c != CNT_MAX) r = c + COUNT_WIDTH'(1);
        end else begin
            if (c != CNT_MIN) r = c - COUNT_WIDTH'(1);
        end
        return r;
    endfunction

    function automatic logic signed [mka_pkg::DELTA_WIDTH-1:0] saturate(
        input logic [PW-1:0] mag,
        input logic          neg
    );
        logic [SAT_W-1:0]                    m;
        logic signed [mka_pkg::DELTA_WIDTH-1:0] r;
        m = SAT_W'(mag);
        if (!neg) begin
            if (m > SAT_W'(mka_pkg::DELTA_MAX)) r = mka_pkg::DELTA_WIDTH'(mka_pkg::DELTA_MAX);
            else r = m[mka_pkg::DELTA_WIDTH-1:0];
        end else begin
            if (m > SAT_W'(mka_pkg::DELTA_MAX) + SAT_W'(1)) begin
                r = {1'b1, {(mka_pkg::DELTA_WIDTH-1){1'b0}}};
            end else begin
                r = -m[mka_pkg::DELTA_WIDTH-1:0];
            end
        end
        return r;
    endfunction

    assign s_accept = s_valid && s_ready;
    assign tick_go  = s_accept && (s_data.cmd == mka_pkg::CMD_TICK) && armed_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mka_pkg::ST_IDLE: begin
                if (tick_go) state_next = mka_pkg::ST_MUL_K;
            end
            mka_pkg::ST_MUL_K: begin
                if (cnt_reg == '0) state_next = mka_pkg::ST_LOAD_C;
            end
            mka_pkg::ST_LOAD_C: begin
                state_next = mka_pkg::ST_MUL_C;
            end
            mka_pkg::ST_MUL_C: begin
                if (cnt_reg == '0) state_next = mka_pkg::ST_DONE;
            end
            mka_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = mka_pkg::ST_IDLE;
            end
            default: begin
                state_next = mka_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready  = 1'b0;
        k_ctl    = '0;
        lane_ctl = '0;
        out_load = 1'b0;
        cnt_next = cnt_reg;
        case (state_reg)
            mka_pkg::ST_IDLE: begin
                s_ready = aresetn;
                if (tick_go) begin
                    k_ctl.load = 1'b1;
                    cnt_next   = CNT_W'(mka_pkg::SPEED_WIDTH - 1);
                end
            end
            mka_pkg::ST_MUL_K: begin
                k_ctl.step = 1'b1;
                cnt_next   = cnt_reg - CNT_W'(1);
            end
            mka_pkg::ST_LOAD_C: begin
                lane_ctl.load = 1'b1;
                cnt_next      = CNT_W'(COUNT_WIDTH - 1);
            end
            mka_pkg::ST_MUL_C: begin
                lane_ctl.step = 1'b1;
                cnt_next      = cnt_reg - CNT_W'(1);
            end
            mka_pkg::ST_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Key event handling and speed update.
    assign step_up = (s_data.direction[0] == s_data.pressed);
    assign x_key = s_data.direction[1] ? count_step(x_count_reg, step_up) : x_count_reg;
    assign y_key = s_data.direction[1] ? y_count_reg : count_step(y_count_reg, step_up);

    always_comb begin
        x_count_next     = x_count_reg;
        y_count_next     = y_count_reg;
        speed_next       = speed_reg;
        scroll_mode_next = scroll_mode_reg;
        armed_next       = armed_reg;
        if (s_accept && (s_data.cmd == mka_pkg::CMD_KEY)) begin
            if (!s_data.auto_repeat) begin
                x_count_next = x_key;
                y_count_next = y_key;
                if (s_data.pressed) scroll_mode_next = s_data.direction[2];
            end
            if ((x_count_next != '0) || (y_count_next != '0)) begin
                armed_next = 1'b1;
            end else begin
                speed_next       = mka_pkg::SPEED_RESET;
                scroll_mode_next = 1'b0;
                armed_next       = 1'b0;
            end
        end else if (tick_go && (speed_reg < speed_max_reg)) begin
            speed_next = speed_reg + mka_pkg::SPEED_WIDTH'(1);
        end
    end

    // Datapath: K = speed * (scroll ? 2 * wheel_scale : 1), then |count| * K per lane.
    assign k_mcand = scroll_mode_reg ? {wheel_scale_reg, 1'b0}
                                     : mka_pkg::KMCAND_WIDTH'(1);
    assign a_src = scroll_mode_reg ? y_count_reg : x_count_reg;
    assign b_src = scroll_mode_reg ? x_count_reg : y_count_reg;
    assign a_mag = a_src[COUNT_WIDTH-1] ? COUNT_WIDTH'(-a_src) : COUNT_WIDTH'(a_src);
    assign b_mag = b_src[COUNT_WIDTH-1] ? COUNT_WIDTH'(-b_src) : COUNT_WIDTH'(b_src);
    assign a_neg = a_src[COUNT_WIDTH-1] ^ scroll_mode_reg;
    assign b_neg = b_src[COUNT_WIDTH-1] ^ scroll_mode_reg;

    mka_ser_mul #(
        .MCAND_WIDTH  (mka_pkg::KMCAND_WIDTH),
        .MPLIER_WIDTH (mka_pkg::SPEED_WIDTH)
    ) u_k_mul (
        .aclk    (aclk),
        .ctl     (k_ctl),
        .mcand   (k_mcand),
        .mplier  (speed_reg),
        .product (k_product)
    );

    mka_ser_mul #(
        .MCAND_WIDTH  (mka_pkg::K_WIDTH),
        .MPLIER_WIDTH (COUNT_WIDTH)
    ) u_a_mul (
        .aclk    (aclk),
        .ctl     (lane_ctl),
        .mcand   (k_product),
        .mplier  (a_mag),
        .product (a_product)
    );

    mka_ser_mul #(
        .MCAND_WIDTH  (mka_pkg::K_WIDTH),
        .MPLIER_WIDTH (COUNT_WIDTH)
    ) u_b_mul (
        .aclk    (aclk),
        .ctl     (lane_ctl),
        .mcand   (k_product),
        .mplier  (b_mag),
        .product (b_product)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next             = 1'b1;
            m_data_next.is_scroll    = scroll_mode_reg;
            m_data_next.first_delta  = saturate(a_product, a_neg);
            m_data_next.second_delta = saturate(b_product, b_neg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mka_pkg::ST_IDLE;
            cnt_reg         <= '0;
            x_count_reg     <= '0;
            y_count_reg     <= '0;
            speed_reg       <= mka_pkg::SPEED_RESET;
            scroll_mode_reg <= 1'b0;
            armed_reg       <= 1'b0;
            speed_max_reg   <= mka_pkg::SPEED_MAX_RESET;
            wheel_scale_reg <= mka_pkg::WHEEL_SCALE_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            x_count_reg     <= x_count_next;
            y_count_reg     <= y_count_next;
            speed_reg       <= speed_next;
            scroll_mode_reg <= scroll_mode_next;
            armed_reg       <= armed_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en && (cfg_addr == mka_pkg::CFG_SPEED_MAX)) begin
                speed_max_reg <= cfg_data[mka_pkg::SPEED_WIDTH-1:0];
            end
            if (cfg_wr_en && (cfg_addr == mka_pkg::CFG_WHEEL_SCALE)) begin
                wheel_scale_reg <= cfg_data[mka_pkg::SCALE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MKA_ASSERT_ALWAYS(a_armed_counts, armed_reg == ((x_count_reg != '0) || (y_count_reg != '0)))
    `MKA_ASSERT_ALWAYS(a_speed_nonzero, speed_reg != '0)
    `MKA_ASSERT_NEXT(a_done_delivers, out_load, m_valid_reg && (state_reg == mka_pkg::ST_IDLE))

endmodule

// ===== rtl/core/mka_ser_mul.sv =====
`timescale 1ns / 1ps

module mka_ser_mul #(
    parameter int MCAND_WIDTH  = 12,
    parameter int MPLIER_WIDTH = 8
) (
    input  logic                                aclk,
    input  mka_pkg::mul_ctl_t                   ctl,
    input  logic [MCAND_WIDTH-1:0]              mcand,
    input  logic [MPLIER_WIDTH-1:0]             mplier,
    output logic [MCAND_WIDTH+MPLIER_WIDTH-1:0] product
);

    localparam int PROD_WIDTH = MCAND_WIDTH + MPLIER_WIDTH;

    logic [PROD_WIDTH-1:0]   acc_reg, acc_next;
    logic [PROD_WIDTH-1:0]   mcand_reg, mcand_next;
    logic [MPLIER_WIDTH-1:0] mplier_reg, mplier_next;

    // Shift-and-add, one multiplier bit per cycle while ctl.step is high, least significant first.
    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (ctl.load) begin
            acc_next    = '0;
            mcand_next  = PROD_WIDTH'(mcand);
            mplier_next = mplier;
        end else if (ctl.step) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign product = acc_reg;

endmodule

// ===== tb/mouse_key_motion_checker.sv =====
`timescale 1ns / 1ps

module mouse_key_motion_checker
    import mka_pkg::*;
#(
    parameter int COUNT_WIDTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  in_word_t                   s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  out_word_t                  m_data,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                         error_count,
    output int                         moves_pending
);

    localparam int     WHEEL_FACTOR = 2;
    localparam int     COUNT_HI     = (1 << (COUNT_WIDTH - 1)) - 1;
    localparam int     COUNT_LO     = -COUNT_HI - 1;
    localparam longint DELTA_HI     = longint'(DELTA_MAX);
    localparam longint DELTA_LO     = -DELTA_HI - 1;

    int                     x_count_q;
    int                     y_count_q;
    logic [SPEED_WIDTH-1:0] speed_q;
    logic [SPEED_WIDTH-1:0] speed_max_q;
    logic [SCALE_WIDTH-1:0] wheel_scale_q;
    logic                   scroll_q;
    logic                   armed_q;
    out_word_t              moves_q[$];
    out_word_t              exp_move;

    function automatic int step_count(int c, int d);
        int n;
        n = c + d;
        if (n > COUNT_HI) n = COUNT_HI;
        if (n < COUNT_LO) n = COUNT_LO;
        return n;
    endfunction

    function automatic logic signed [DELTA_WIDTH-1:0] clamp_delta(longint v);
        if (v > DELTA_HI) v = DELTA_HI;
        if (v < DELTA_LO) v = DELTA_LO;
        return v[DELTA_WIDTH-1:0];
    endfunction

    task automatic predict_motion(in_word_t w);
        int        step;
        longint    k;
        out_word_t mv;
        if (w.cmd == CMD_KEY) begin
            if (!w.auto_repeat) begin
                step = w.direction[0] ? 1 : -1;
                if (!w.pressed) step = -step;
                if (w.direction[1]) x_count_q = step_count(x_count_q, step);
                else y_count_q = step_count(y_count_q, step);
                if (w.pressed) scroll_q = w.direction[2];
            end
            if (x_count_q != 0 || y_count_q != 0) begin
                armed_q = 1'b1;
            end else begin
                speed_q  = SPEED_RESET;
                scroll_q = 1'b0;
                armed_q  = 1'b0;
            end
        end else if (armed_q) begin
            if (!scroll_q) begin
                mv.is_scroll    = 1'b0;
                mv.first_delta  = clamp_delta(longint'(x_count_q) * longint'(speed_q));
                mv.second_delta = clamp_delta(longint'(y_count_q) * longint'(speed_q));
            end else begin
                k = longint'(speed_q) * WHEEL_FACTOR * longint'(wheel_scale_q);
                mv.is_scroll    = 1'b1;
                mv.first_delta  = clamp_delta(-(longint'(y_count_q) * k));
                mv.second_delta = clamp_delta(-(longint'(x_count_q) * k));
            end
            moves_q.push_back(mv);
            if (speed_q < speed_max_q) speed_q = speed_q + 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            x_count_q     = 0;
            y_count_q     = 0;
            speed_q       = SPEED_RESET;
            speed_max_q   = SPEED_MAX_RESET;
            wheel_scale_q = WHEEL_SCALE_RESET;
            scroll_q      = 1'b0;
            armed_q       = 1'b0;
            error_count   = 0;
            moves_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_SPEED_MAX) speed_max_q = cfg_data[SPEED_WIDTH-1:0];
                else if (cfg_addr == CFG_WHEEL_SCALE) wheel_scale_q = cfg_data[SCALE_WIDTH-1:0];
            end
            if (m_valid && m_ready) begin
                if (moves_q.size() == 0) begin
                    $error("unexpected word: is_scroll %0b first_delta %0d second_delta %0d",
                           m_data.is_scroll, m_data.first_delta, m_data.second_delta);
                    error_count++;
                end else begin
                    exp_move = moves_q.pop_front();
                    if (m_data.is_scroll !== exp_move.is_scroll) begin
                        $error("is_scroll: expected %0b, actual %0b",
                               exp_move.is_scroll, m_data.is_scroll);
                        error_count++;
                    end
                    if (m_data.first_delta !== exp_move.first_delta) begin
                        $error("first_delta: expected %0d, actual %0d",
                               exp_move.first_delta, m_data.first_delta);
                        error_count++;
                    end
                    if (m_data.second_delta !== exp_move.second_delta) begin
                        $error("second_delta: expected %0d, actual %0d",
                               exp_move.second_delta, m_data.second_delta);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) predict_motion(s_data);
        end
        moves_pending <= moves_q.size();
    end

endmodule

// ===== tb/mouse_key_accelerator_core_tb.sv =====
`timescale 1ns / 1ps

module mouse_key_accelerator_core_tb;

    import mka_pkg::*;

    localparam int COUNT_WIDTH      = 4;
    localparam int SETTLE_CYCLES    = 2 * (COUNT_WIDTH + 11);
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS      = 160;

    localparam logic [2:0] DIR_UP           = 3'd0;
    localparam logic [2:0] DIR_DOWN         = 3'd1;
    localparam logic [2:0] DIR_LEFT         = 3'd2;
    localparam logic [2:0] DIR_RIGHT        = 3'd3;
    localparam logic [2:0] DIR_SCROLL_UP    = 3'd4;
    localparam logic [2:0] DIR_SCROLL_DOWN  = 3'd5;
    localparam logic [2:0] DIR_SCROLL_LEFT  = 3'd6;
    localparam logic [2:0] DIR_SCROLL_RIGHT = 3'd7;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    in_word_t                   s_data;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    out_word_t                  m_data;
    logic                       cfg_wr_en;
    logic [CFG_INDEX_WIDTH-1:0] cfg_addr;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    int error_count;
    int moves_pending;
    int idle_pct;
    int stall_pct = 0;
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int items_sent;

    mouse_key_accelerator_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    mouse_key_motion_checker #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .moves_pending(moves_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    // A request for a long hold-off is signalled by bumping hold_seq.
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= LONG_HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic in_word_t key_word(logic [2:0] dir, logic down, logic rep);
        in_word_t w;
        w.cmd         = CMD_KEY;
        w.direction   = dir;
        w.pressed     = down;
        w.auto_repeat = rep;
        return w;
    endfunction

    function automatic in_word_t noise_word();
        in_word_t w;
        w = in_word_t'(6'($urandom_range(63)));
        return w;
    endfunction

    function automatic in_word_t tick_word();
        in_word_t w;
        w     = noise_word();
        w.cmd = CMD_TICK;
        return w;
    endfunction

    task automatic send_word(in_word_t w);
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (moves_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(logic [CFG_DATA_WIDTH-1:0] speed_word,
                             logic [CFG_DATA_WIDTH-1:0] scale_word);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_SPEED_MAX;
        cfg_data  <= speed_word;
        @(posedge aclk);
        cfg_addr  <= CFG_WHEEL_SCALE;
        cfg_data  <= scale_word;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_session();
        logic [2:0] dirs[3];
        int         reps[3];
        int         n_keys;
        n_keys = $urandom_range(1, 3);
        for (int i = 0; i < n_keys; i++) begin
            dirs[i] = 3'($urandom_range(7));
            reps[i] = ($urandom_range(7) == 0) ? $urandom_range(8, 10) : 1;
            repeat (reps[i]) send_word(key_word(dirs[i], 1'b1, 1'b0));
            repeat ($urandom_range(0, 3)) send_word(tick_word());
        end
        repeat ($urandom_range(1, 24)) begin
            case ($urandom_range(19))
                0: begin
                    send_word(key_word(dirs[0], 1'b1, 1'b1));
                end
                1: begin
                    send_word(noise_word());
                end
                default: begin
                    send_word(tick_word());
                end
            endcase
        end
        for (int i = 0; i < n_keys; i++) begin
            if ($urandom_range(9) == 0) reps[i] = $urandom_range(0, reps[i] + 1);
            repeat (reps[i]) send_word(key_word(dirs[i], 1'b0, 1'b0));
            repeat ($urandom_range(0, 2)) send_word(tick_word());
        end
    endtask

    initial begin
        int  phase_start;
        bit  held;
        bit  paused;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        idle_pct   = 0;
        items_sent = 0;
        held       = 1'b0;
        paused     = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(tick_word());
        send_word(key_word(DIR_DOWN, 1'b1, 1'b1));
        send_word(key_word(DIR_UP, 1'b1, 1'b0));
        send_word(tick_word());
        send_word(key_word(DIR_LEFT, 1'b1, 1'b0));
        send_word(tick_word());
        send_word(key_word(DIR_RIGHT, 1'b1, 1'b1));
        send_word(tick_word());
        send_word(key_word(DIR_UP, 1'b0, 1'b0));
        send_word(tick_word());
        send_word(key_word(DIR_LEFT, 1'b0, 1'b0));
        send_word(tick_word());
        send_word(key_word(DIR_SCROLL_DOWN, 1'b1, 1'b0));
        send_word(tick_word());
        send_word(key_word(DIR_SCROLL_RIGHT, 1'b1, 1'b0));
        send_word(tick_word());
        send_word(key_word(DIR_SCROLL_DOWN, 1'b0, 1'b0));
        send_word(key_word(DIR_SCROLL_RIGHT, 1'b0, 1'b0));
        send_word(key_word(DIR_SCROLL_UP, 1'b1, 1'b0));
        send_word(tick_word());
        send_word(key_word(DIR_SCROLL_LEFT, 1'b1, 1'b0));
        send_word(tick_word());
        send_word(key_word(DIR_SCROLL_UP, 1'b0, 1'b0));
        send_word(key_word(DIR_SCROLL_LEFT, 1'b0, 1'b0));
        repeat (8) send_word(key_word(DIR_RIGHT, 1'b1, 1'b0));
        send_word(tick_word());
        repeat (7) send_word(key_word(DIR_RIGHT, 1'b0, 1'b0));
        send_word(tick_word());
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    configure(11'd255, 11'd1024);
                    // The speed climbs all the way to its ceiling here.
                    send_word(key_word(DIR_RIGHT, 1'b1, 1'b0));
                    repeat (260) send_word(tick_word());
                    send_word(key_word(DIR_RIGHT, 1'b0, 1'b0));
                end
                1: begin
                    idle_pct = 45;
                    stall_pct <= 0;
                    configure({3'b111, 8'd1}, 11'd2047);
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 45;
                    configure(11'd0, 11'd0);
                end
                default: begin
                    idle_pct = 9;
                    stall_pct <= 9;
                    configure({3'($urandom_range(7)), 8'($urandom_range(1, 255))},
                              11'($urandom_range(2047)));
                end
            endcase
            phase_start = items_sent;
            while (items_sent < phase_start + PHASE_ITEMS) begin
                if (p == 3 && !held && items_sent >= phase_start + 50) begin
                    hold_seq <= hold_seq + 1;
                    held = 1'b1;
                end
                if (p == 1 && !paused && items_sent >= phase_start + 100) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 80) run_session();
                else send_word(noise_word());
            end
            drain();
        end

        if (error_count == 0 && moves_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
